@@ rtl/bepu_pkg.sv @@
// Package for the Brownian position update core: field widths, pipeline depths,
// register indexes and the structs that travel between the pipeline modules.
// No dependencies.
package bepu_pkg;

   localparam int CFG_W       = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int MASK_W      = 32;
   localparam int MASS_W      = 32;
   localparam int POS_W       = 32;
   localparam int FRC_W       = 32;
   localparam int NOISE_W     = 16;
   localparam int ROOT_W      = 24;
   localparam int RAD_W       = 48;
   localparam int GAIN_W      = 40;
   localparam int PROD_W      = 64;
   localparam int TMAG_W      = 44;
   localparam int TERM_W      = 45;
   localparam int SUM_W       = 46;
   localparam int SMAG_W      = 45;
   localparam int SCALE_LIM_W = 49;
   localparam int FULL_W      = 95;
   localparam int DMAG_W      = 33;
   localparam int RES_W       = 35;

   localparam int SQRT_STAGES = 24;
   localparam int DIV_STAGES  = 64;
   localparam int LANE_STAGES = 5;
   localparam int AXES        = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_FORCE_TIME_FACTOR = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_STEP_TIME         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_NOISE_GAIN        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_GROUP_BIT         = 3'd3;

   localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7fffffff;
   localparam logic signed [POS_W-1:0] POS_MIN = 32'sh80000000;

   typedef struct packed {
      logic signed [POS_W-1:0]   pos;
      logic signed [FRC_W-1:0]   frc;
      logic signed [NOISE_W-1:0] noise;
   } axis_type;

   typedef struct packed {
      axis_type [AXES-1:0] axis;
      logic                moved;
      logic                last_atom;
   } atom_type;

   typedef struct packed {
      atom_type            atom;
      logic [MASS_W-1:0]   mass;
      logic [PROD_W-1:0]   prod;
   } sqrt_side_type;

   typedef struct packed {
      atom_type            atom;
      logic [GAIN_W-1:0]   gain;
   } div_side_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos;
      logic signed [POS_W-1:0] value;
      logic                    sat;
   } lane_res_type;

endpackage

@@ rtl/brownian_euler_position_update_core.sv @@
// Top level of the Brownian position update core: capture, product, gain,
// lanes and merge stage. Depends on bepu_pkg, bepu_sqrt, bepu_div, bepu_lane.
//
// Usage: the host writes the four registers through csr_wr_en, csr_index and
// csr_wdata while no transaction is in flight, then streams one atom per
// transaction on the req_ channel. Each atom yields exactly one rsp_
// transaction, in order.
// The block is one pipeline of 97 register stages: capture, the time product,
// 24 square-root stages, the gain multiply, 64 divider stages, five lane
// stages per axis and the output register. One atom is accepted every cycle
// while the pipeline is not held by rsp_stall.
// When the output register holds a result and rsp_stall is high, the whole
// pipeline holds and req_stall is raised; otherwise the block keeps taking
// atoms. Reset clears all valid bits and loads the register reset values;
// no result is pending afterwards.
module brownian_euler_position_update_core
   import bepu_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CFG_W-1:0]          csr_wdata,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [MASK_W-1:0]         req_group_mask,
   input  logic [MASS_W-1:0]         req_atom_mass,
   input  logic signed [FRC_W-1:0]   req_force_x,
   input  logic signed [FRC_W-1:0]   req_force_y,
   input  logic signed [FRC_W-1:0]   req_force_z,
   input  logic signed [NOISE_W-1:0] req_noise_x,
   input  logic signed [NOISE_W-1:0] req_noise_y,
   input  logic signed [NOISE_W-1:0] req_noise_z,
   input  logic signed [POS_W-1:0]   req_pos_x,
   input  logic signed [POS_W-1:0]   req_pos_y,
   input  logic signed [POS_W-1:0]   req_pos_z,
   input  logic                      req_last_atom,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [POS_W-1:0]   rsp_new_x,
   output logic signed [POS_W-1:0]   rsp_new_y,
   output logic signed [POS_W-1:0]   rsp_new_z,
   output logic                      rsp_moved,
   output logic                      rsp_saturated,
   output logic                      rsp_last_out
);

   logic [CFG_W-1:0]   ftf_ff;
   logic [CFG_W-1:0]   step_ff;
   logic [CFG_W-1:0]   ngain_ff;
   logic [CFG_W-1:0]   group_ff;

   logic               en;
   atom_type           cap_atom_in;

   logic               cap_valid_ff;
   atom_type           cap_atom_ff;
   logic [MASS_W-1:0]  cap_mass_ff;

   logic               prod_valid_ff;
   sqrt_side_type      prod_side_ff;

   logic               sqrt_valid;
   sqrt_side_type      sqrt_side;
   logic [ROOT_W-1:0]  sqrt_root;

   logic [ROOT_W+CFG_W-1:0] gprod;
   logic               gain_valid_ff;
   div_side_type       gain_side_ff;
   logic [MASS_W-1:0]  gain_mass_ff;
   logic [PROD_W-1:0]  gain_prod_ff;

   logic               div_valid;
   logic [PROD_W-1:0]  div_quot;
   div_side_type       div_side;

   logic               lane_valid_ff [LANE_STAGES];
   logic               lane_moved_ff [LANE_STAGES];
   logic               lane_last_ff  [LANE_STAGES];
   lane_res_type       lane_res      [AXES];

   logic               rsp_valid_ff;
   logic signed [POS_W-1:0] rsp_new_ff [AXES];
   logic               rsp_moved_ff;
   logic               rsp_sat_ff;
   logic               rsp_last_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         ftf_ff   <= '0;
         step_ff  <= '0;
         ngain_ff <= '0;
         group_ff <= CFG_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_FORCE_TIME_FACTOR: ftf_ff   <= csr_wdata;
            REG_STEP_TIME:         step_ff  <= csr_wdata;
            REG_NOISE_GAIN:        ngain_ff <= csr_wdata;
            REG_GROUP_BIT:         group_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cap_atom_in.axis[0]   = '{pos: req_pos_x, frc: req_force_x, noise: req_noise_x};
      cap_atom_in.axis[1]   = '{pos: req_pos_y, frc: req_force_y, noise: req_noise_y};
      cap_atom_in.axis[2]   = '{pos: req_pos_z, frc: req_force_z, noise: req_noise_z};
      cap_atom_in.moved     = |(req_group_mask & group_ff);
      cap_atom_in.last_atom = req_last_atom;
   end

   always_comb begin
      gprod = (ROOT_W+CFG_W)'(sqrt_root) * (ROOT_W+CFG_W)'(ngain_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         gain_valid_ff <= 1'b0;
      end else if (en) begin
         cap_valid_ff  <= req_valid;
         prod_valid_ff <= cap_valid_ff;
         gain_valid_ff <= sqrt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cap_atom_ff  <= cap_atom_in;
         cap_mass_ff  <= (req_atom_mass == '0) ? MASS_W'(1) : req_atom_mass;

         prod_side_ff.atom <= cap_atom_ff;
         prod_side_ff.mass <= cap_mass_ff;
         prod_side_ff.prod <= PROD_W'(step_ff) * PROD_W'(ftf_ff);

         gain_side_ff.atom <= sqrt_side.atom;
         gain_side_ff.gain <= gprod[ROOT_W+CFG_W-1:16];
         gain_mass_ff      <= sqrt_side.mass;
         gain_prod_ff      <= sqrt_side.prod;
      end
   end

   bepu_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (prod_valid_ff),
      .in_side   (prod_side_ff),
      .out_valid (sqrt_valid),
      .out_side  (sqrt_side),
      .out_root  (sqrt_root)
   );

   bepu_div u_div (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (gain_valid_ff),
      .in_dividend  (gain_prod_ff),
      .in_divisor   (gain_mass_ff),
      .in_side      (gain_side_ff),
      .out_valid    (div_valid),
      .out_quotient (div_quot),
      .out_side     (div_side)
   );

   for (genvar k = 0; k < AXES; k++) begin : g_lane
      bepu_lane u_lane (
         .clock    (clock),
         .en       (en),
         .in_axis  (div_side.atom.axis[k]),
         .in_scale (div_quot),
         .in_gain  (div_side.gain),
         .out_res  (lane_res[k])
      );
   end

   for (genvar i = 0; i < LANE_STAGES; i++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (reset) begin
            lane_valid_ff[i] <= 1'b0;
         end else if (en) begin
            lane_valid_ff[i] <= (i == 0) ? div_valid : lane_valid_ff[(i == 0) ? 0 : i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            lane_moved_ff[i] <= (i == 0) ? div_side.atom.moved
                                         : lane_moved_ff[(i == 0) ? 0 : i-1];
            lane_last_ff[i]  <= (i == 0) ? div_side.atom.last_atom
                                         : lane_last_ff[(i == 0) ? 0 : i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= lane_valid_ff[LANE_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < AXES; k++) begin
            rsp_new_ff[k] <= lane_moved_ff[LANE_STAGES-1] ? lane_res[k].value
                                                          : lane_res[k].pos;
         end
         rsp_moved_ff <= lane_moved_ff[LANE_STAGES-1];
         rsp_sat_ff   <= lane_moved_ff[LANE_STAGES-1] &&
                         (lane_res[0].sat || lane_res[1].sat || lane_res[2].sat);
         rsp_last_ff  <= lane_last_ff[LANE_STAGES-1];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_new_x     = rsp_new_ff[0];
   assign rsp_new_y     = rsp_new_ff[1];
   assign rsp_new_z     = rsp_new_ff[2];
   assign rsp_moved     = rsp_moved_ff;
   assign rsp_saturated = rsp_sat_ff;
   assign rsp_last_out  = rsp_last_ff;

endmodule

@@ rtl/bepu_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, of mass * 2^16.
// Carries the atom sideband alongside. Depends on bepu_pkg.
module bepu_sqrt
   import bepu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  sqrt_side_type       in_side,
   output logic                out_valid,
   output sqrt_side_type       out_side,
   output logic [ROOT_W-1:0]   out_root
);

   logic                valid_ff [SQRT_STAGES];
   sqrt_side_type       side_ff  [SQRT_STAGES];
   logic [ROOT_W+1:0]   rem_ff   [SQRT_STAGES];
   logic [ROOT_W+1:0]   rem_in   [SQRT_STAGES];
   logic [ROOT_W-1:0]   root_ff  [SQRT_STAGES];
   logic [ROOT_W-1:0]   root_in  [SQRT_STAGES];
   logic [RAD_W-1:0]    rad_ff   [SQRT_STAGES];
   logic [RAD_W-1:0]    rad_in   [SQRT_STAGES];

   for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
      logic              v_p;
      sqrt_side_type     s_p;
      logic [ROOT_W+1:0] rem_p;
      logic [ROOT_W-1:0] root_p;
      logic [RAD_W-1:0]  rad_p;
      logic [ROOT_W+2:0] rem_x;
      logic [ROOT_W+2:0] trial;

      if (i == 0) begin : g_first
         assign v_p    = in_valid;
         assign s_p    = in_side;
         assign rem_p  = '0;
         assign root_p = '0;
         assign rad_p  = {in_side.mass, 16'd0};
      end else begin : g_next
         assign v_p    = valid_ff[i-1];
         assign s_p    = side_ff[i-1];
         assign rem_p  = rem_ff[i-1];
         assign root_p = root_ff[i-1];
         assign rad_p  = rad_ff[i-1];
      end

      always_comb begin
         rem_x     = {rem_p[ROOT_W:0], rad_p[RAD_W-1 -: 2]};
         trial     = {1'b0, root_p, 2'b01};
         rad_in[i] = {rad_p[RAD_W-3:0], 2'b00};
         if (rem_x >= trial) begin
            rem_in[i]  = (ROOT_W+2)'(rem_x - trial);
            root_in[i] = {root_p[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[i]  = rem_x[ROOT_W+1:0];
            root_in[i] = {root_p[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[i] <= s_p;
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
            rad_ff[i]  <= rad_in[i];
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STAGES-1];
   assign out_side  = side_ff[SQRT_STAGES-1];
   assign out_root  = root_ff[SQRT_STAGES-1];

endmodule

@@ rtl/bepu_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, 64-bit by 32-bit.
// Carries the atom sideband alongside. Depends on bepu_pkg.
module bepu_div
   import bepu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [PROD_W-1:0]   in_dividend,
   input  logic [MASS_W-1:0]   in_divisor,
   input  div_side_type        in_side,
   output logic                out_valid,
   output logic [PROD_W-1:0]   out_quotient,
   output div_side_type        out_side
);

   logic                valid_ff [DIV_STAGES];
   div_side_type        side_ff  [DIV_STAGES];
   logic [PROD_W-1:0]   dq_ff    [DIV_STAGES];
   logic [PROD_W-1:0]   dq_in    [DIV_STAGES];
   logic [MASS_W-1:0]   rem_ff   [DIV_STAGES];
   logic [MASS_W-1:0]   rem_in   [DIV_STAGES];
   logic [MASS_W-1:0]   dvs_ff   [DIV_STAGES];

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
      logic              v_p;
      div_side_type      s_p;
      logic [PROD_W-1:0] dq_p;
      logic [MASS_W-1:0] rem_p;
      logic [MASS_W-1:0] dvs_p;
      logic [MASS_W:0]   rem_x;

      if (i == 0) begin : g_first
         assign v_p   = in_valid;
         assign s_p   = in_side;
         assign dq_p  = in_dividend;
         assign rem_p = '0;
         assign dvs_p = in_divisor;
      end else begin : g_next
         assign v_p   = valid_ff[i-1];
         assign s_p   = side_ff[i-1];
         assign dq_p  = dq_ff[i-1];
         assign rem_p = rem_ff[i-1];
         assign dvs_p = dvs_ff[i-1];
      end

      always_comb begin
         rem_x = {rem_p, dq_p[PROD_W-1]};
         if (rem_x >= {1'b0, dvs_p}) begin
            rem_in[i] = MASS_W'(rem_x - {1'b0, dvs_p});
            dq_in[i]  = {dq_p[PROD_W-2:0], 1'b1};
         end else begin
            rem_in[i] = rem_x[MASS_W-1:0];
            dq_in[i]  = {dq_p[PROD_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[i] <= s_p;
            dq_ff[i]   <= dq_in[i];
            rem_ff[i]  <= rem_in[i];
            dvs_ff[i]  <= dvs_p;
         end
      end
   end

   assign out_valid    = valid_ff[DIV_STAGES-1];
   assign out_quotient = dq_ff[DIV_STAGES-1];
   assign out_side     = side_ff[DIV_STAGES-1];

endmodule

@@ rtl/bepu_lane.sv @@
// One axis lane: noise term, force sum, split scale product and saturating add.
// Five register stages of payload only. Depends on bepu_pkg.
module bepu_lane
   import bepu_pkg::*;
(
   input  logic                clock,
   input  logic                en,
   input  axis_type            in_axis,
   input  logic [PROD_W-1:0]   in_scale,
   input  logic [GAIN_W-1:0]   in_gain,
   output lane_res_type        out_res
);

   logic [NOISE_W-1:0]        nmag;
   logic [GAIN_W+NOISE_W-1:0] tprod;

   logic [TMAG_W-1:0]         l1_tmag_ff;
   logic                      l1_nneg_ff;
   logic signed [FRC_W-1:0]   l1_frc_ff;
   logic signed [POS_W-1:0]   l1_pos_ff;
   logic [PROD_W-1:0]         l1_scale_ff;

   logic signed [TERM_W-1:0]  term;
   logic signed [SUM_W-1:0]   sum;
   logic [SMAG_W-1:0]         smag_in;

   logic                      l2_neg_ff;
   logic [SMAG_W-1:0]         l2_smag_ff;
   logic                      l2_sbig_ff;
   logic [SCALE_LIM_W-1:0]    l2_s49_ff;
   logic signed [POS_W-1:0]   l2_pos_ff;

   logic                      l3_neg_ff;
   logic                      l3_ovf_ff;
   logic [47:0]               l3_pp_ll_ff;
   logic [44:0]               l3_pp_lh_ff;
   logic [48:0]               l3_pp_hl_ff;
   logic [45:0]               l3_pp_hh_ff;
   logic signed [POS_W-1:0]   l3_pos_ff;

   logic [FULL_W-1:0]         full;

   logic                      l4_neg_ff;
   logic                      l4_ovf_ff;
   logic [DMAG_W-1:0]         l4_dmag_ff;
   logic signed [POS_W-1:0]   l4_pos_ff;

   logic signed [RES_W-1:0]   delta;
   logic signed [RES_W-1:0]   res;
   lane_res_type              l5_res_in;
   lane_res_type              l5_res_ff;

   always_comb begin
      nmag  = in_axis.noise[NOISE_W-1] ? NOISE_W'(-in_axis.noise) : NOISE_W'(in_axis.noise);
      tprod = (GAIN_W+NOISE_W)'(in_gain) * (GAIN_W+NOISE_W)'(nmag);
   end

   always_comb begin
      term = l1_nneg_ff ? -$signed({1'b0, l1_tmag_ff}) : $signed({1'b0, l1_tmag_ff});
      sum  = SUM_W'(l1_frc_ff) + SUM_W'(term);
      smag_in = sum[SUM_W-1] ? SMAG_W'(-sum) : sum[SMAG_W-1:0];
   end

   always_comb begin
      full = FULL_W'(l3_pp_ll_ff)
           + (FULL_W'(l3_pp_lh_ff) << 24)
           + (FULL_W'(l3_pp_hl_ff) << 24)
           + (FULL_W'(l3_pp_hh_ff) << 48);
   end

   always_comb begin
      delta = l4_neg_ff ? -$signed({2'b00, l4_dmag_ff}) : $signed({2'b00, l4_dmag_ff});
      res   = RES_W'(l4_pos_ff) + delta;
      l5_res_in.pos = l4_pos_ff;
      if (l4_ovf_ff) begin
         l5_res_in.value = l4_neg_ff ? POS_MIN : POS_MAX;
         l5_res_in.sat   = 1'b1;
      end else if (res > RES_W'(POS_MAX)) begin
         l5_res_in.value = POS_MAX;
         l5_res_in.sat   = 1'b1;
      end else if (res < RES_W'(POS_MIN)) begin
         l5_res_in.value = POS_MIN;
         l5_res_in.sat   = 1'b1;
      end else begin
         l5_res_in.value = res[POS_W-1:0];
         l5_res_in.sat   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l1_tmag_ff  <= tprod[GAIN_W+NOISE_W-1:12];
         l1_nneg_ff  <= in_axis.noise[NOISE_W-1];
         l1_frc_ff   <= in_axis.frc;
         l1_pos_ff   <= in_axis.pos;
         l1_scale_ff <= in_scale;

         l2_neg_ff   <= sum[SUM_W-1];
         l2_smag_ff  <= smag_in;
         l2_sbig_ff  <= |l1_scale_ff[PROD_W-1:SCALE_LIM_W];
         l2_s49_ff   <= l1_scale_ff[SCALE_LIM_W-1:0];
         l2_pos_ff   <= l1_pos_ff;

         l3_neg_ff   <= l2_neg_ff;
         l3_ovf_ff   <= l2_sbig_ff && (l2_smag_ff != '0);
         l3_pp_ll_ff <= 48'(l2_s49_ff[23:0]) * 48'(l2_smag_ff[23:0]);
         l3_pp_lh_ff <= 45'(l2_s49_ff[23:0]) * 45'(l2_smag_ff[SMAG_W-1:24]);
         l3_pp_hl_ff <= 49'(l2_s49_ff[SCALE_LIM_W-1:24]) * 49'(l2_smag_ff[23:0]);
         l3_pp_hh_ff <= 46'(l2_s49_ff[SCALE_LIM_W-1:24]) * 46'(l2_smag_ff[SMAG_W-1:24]);
         l3_pos_ff   <= l2_pos_ff;

         l4_neg_ff   <= l3_neg_ff;
         l4_ovf_ff   <= l3_ovf_ff || (|full[FULL_W-1:SCALE_LIM_W]);
         l4_dmag_ff  <= full[SCALE_LIM_W-1:16];
         l4_pos_ff   <= l3_pos_ff;

         l5_res_ff   <= l5_res_in;
      end
   end

   assign out_res = l5_res_ff;

endmodule

@@ rtl/bepu_checker.sv @@
// Port-level checker for the Brownian position update core and its bind.
// Depends on bepu_pkg and brownian_euler_position_update_core.
module bepu_checker
   import bepu_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_stall,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic signed [POS_W-1:0]   rsp_new_x,
   input  logic signed [POS_W-1:0]   rsp_new_y,
   input  logic signed [POS_W-1:0]   rsp_new_z,
   input  logic                      rsp_moved,
   input  logic                      rsp_saturated,
   input  logic                      rsp_last_out
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_new_x) && $stable(rsp_new_y)
         && $stable(rsp_new_z) && $stable(rsp_last_out))
      else $error("Stalled result transaction changed.");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("Request stalled without a blocked result transaction.");

   a_sat_moved: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_moved)
      else $error("Saturation flagged on an atom that was not moved.");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_new_x == POS_MAX || rsp_new_x == POS_MIN ||
         rsp_new_y == POS_MAX || rsp_new_y == POS_MIN ||
         rsp_new_z == POS_MAX || rsp_new_z == POS_MIN)
      else $error("Saturation flagged but no component is at a limit.");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("Result transaction pending right after reset.");

endmodule

bind brownian_euler_position_update_core bepu_checker u_bepu_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_new_x     (rsp_new_x),
   .rsp_new_y     (rsp_new_y),
   .rsp_new_z     (rsp_new_z),
   .rsp_moved     (rsp_moved),
   .rsp_saturated (rsp_saturated),
   .rsp_last_out  (rsp_last_out)
);

@@ dv/tb_brownian_euler_position_update_core.sv @@
// Self-checking testbench for the Brownian position update core: directed and random atoms
// are checked against a fixed-point Euler-Maruyama predictor under random stalls.
// Depends on bepu_pkg and brownian_euler_position_update_core.
class bepu_scoreboard;
   typedef struct {
      logic [31:0] nx, ny, nz;
      logic        moved, sat, last;
   } atom_result_type;

   logic [31:0]     force_time_factor, step_time, noise_gain, group_bit;
   atom_result_type pending_results[$];
   int              errors;
   int              checked;
   int              moved_count;
   int              sat_count;

   function new();
      force_time_factor = 0;
      step_time = 0;
      noise_gain = 0;
      group_bit = 1;
      errors = 0;
      checked = 0;
      moved_count = 0;
      sat_count = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
         bepu_pkg::REG_FORCE_TIME_FACTOR: force_time_factor = val;
         bepu_pkg::REG_STEP_TIME:         step_time = val;
         bepu_pkg::REG_NOISE_GAIN:        noise_gain = val;
         bepu_pkg::REG_GROUP_BIT:         group_bit = val;
         default: ;
      endcase
   endfunction

   function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function logic [31:0] move_axis(logic signed [31:0] pos, logic signed [31:0] frc,
                                   logic signed [15:0] noise, logic [63:0] gain,
                                   logic [63:0] scale, inout logic sat);
      logic [63:0]         nmag, tmag, smag, dmag;
      logic signed [63:0]  term, sum, res;
      logic [127:0]        prod;
      nmag = noise < 0 ? 64'(-64'(noise)) : 64'(noise);
      tmag = (gain * nmag) >> 12;
      term = noise < 0 ? -$signed(tmag) : $signed(tmag);
      sum = 64'(frc) + term;
      smag = sum < 0 ? 64'(-sum) : 64'(sum);
      prod = 128'(scale) * 128'(smag);
      if (prod >= (128'd1 << 65)) begin
         res = sum < 0 ? -64'sd4294967296 : 64'sd4294967296;
      end else begin
         dmag = 64'(prod >> 16);
         res = 64'(pos) + (sum < 0 ? -$signed(dmag) : $signed(dmag));
      end
      if (res > 64'sd2147483647) begin
         sat = 1;
         return 32'h7fffffff;
      end
      if (res < -64'sd2147483648) begin
         sat = 1;
         return 32'h80000000;
      end
      return res[31:0];
   endfunction

   function void note_atom(logic [31:0] mask, logic [31:0] mass,
                           logic [31:0] fx, fy, fz, logic [15:0] nx, ny, nz,
                           logic [31:0] px, py, pz, logic last);
      atom_result_type r;
      logic [63:0]     m, root, gain, scale;
      logic            sat;
      r.moved = (mask & group_bit) != 0;
      r.last = last;
      r.nx = px;
      r.ny = py;
      r.nz = pz;
      sat = 0;
      if (r.moved) begin
         m = mass == 0 ? 64'd1 : 64'(mass);
         root = int_sqrt(m << 16);
         gain = (root * 64'(noise_gain)) >> 16;
         scale = (64'(step_time) * 64'(force_time_factor)) / m;
         r.nx = move_axis(px, fx, nx, gain, scale, sat);
         r.ny = move_axis(py, fy, ny, gain, scale, sat);
         r.nz = move_axis(pz, fz, nz, gain, scale, sat);
      end
      r.sat = sat;
      pending_results.push_back(r);
   endfunction

   function void check_result(logic [31:0] nx, ny, nz, logic moved, sat, last);
      atom_result_type e;
      checked++;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected transaction new=%h %h %h", $time, nx, ny, nz);
         errors++;
         return;
      end
      e = pending_results.pop_front();
      moved_count += moved;
      sat_count += sat;
      if (nx !== e.nx) begin
         $display("%0t: new_x expected %h actual %h", $time, e.nx, nx);
         errors++;
      end
      if (ny !== e.ny) begin
         $display("%0t: new_y expected %h actual %h", $time, e.ny, ny);
         errors++;
      end
      if (nz !== e.nz) begin
         $display("%0t: new_z expected %h actual %h", $time, e.nz, nz);
         errors++;
      end
      if (moved !== e.moved) begin
         $display("%0t: moved expected %b actual %b", $time, e.moved, moved);
         errors++;
      end
      if (sat !== e.sat) begin
         $display("%0t: saturated expected %b actual %b", $time, e.sat, sat);
         errors++;
      end
      if (last !== e.last) begin
         $display("%0t: last_out expected %b actual %b", $time, e.last, last);
         errors++;
      end
   endfunction
endclass

module tb_brownian_euler_position_update_core;
   import bepu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                      clock = 0;
   logic                      reset = 1;
   logic                      csr_wr_en = 0;
   logic [CSR_INDEX_W-1:0]    csr_index = REG_FORCE_TIME_FACTOR;
   logic [CFG_W-1:0]          csr_wdata = 0;
   logic                      req_valid = 0;
   logic                      req_stall;
   logic [MASK_W-1:0]         req_group_mask = 0;
   logic [MASS_W-1:0]         req_atom_mass = 0;
   logic signed [FRC_W-1:0]   req_force_x = 0, req_force_y = 0, req_force_z = 0;
   logic signed [NOISE_W-1:0] req_noise_x = 0, req_noise_y = 0, req_noise_z = 0;
   logic signed [POS_W-1:0]   req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic                      req_last_atom = 0;
   logic                      rsp_valid;
   logic                      rsp_stall = 0;
   logic signed [POS_W-1:0]   rsp_new_x, rsp_new_y, rsp_new_z;
   logic                      rsp_moved, rsp_saturated, rsp_last_out;

   bepu_scoreboard position_board = new();
   bit                         draining = 0;

   brownian_euler_position_update_core i_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         position_board.check_result(rsp_new_x, rsp_new_y, rsp_new_z,
                                     rsp_moved, rsp_saturated, rsp_last_out);
   end

   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (n > 0) begin
            n--;
         end else if (rsp_stall) begin
            rsp_stall <= 0;
            n = draining ? 0 : $urandom_range(0, 20);
         end else if (!draining) begin
            n = gap_length();
            if (n > 0 && $urandom_range(0, 2) == 0) rsp_stall <= 1;
            else n = 0;
         end
      end
   end

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 0;
      position_board.write_reg(idx, val);
   endtask

   task automatic wait_idle();
      while (position_board.pending_results.size() != 0) @(posedge clock);
      repeat (110) @(posedge clock);
   endtask

   task automatic send_atom(logic [31:0] mask, mass, fx, fy, fz,
                            logic [15:0] nx, ny, nz, logic [31:0] px, py, pz,
                            logic last);
      req_valid <= 1;
      req_group_mask <= mask;
      req_atom_mass <= mass;
      req_force_x <= fx;
      req_force_y <= fy;
      req_force_z <= fz;
      req_noise_x <= nx;
      req_noise_y <= ny;
      req_noise_z <= nz;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      req_last_atom <= last;
      do @(posedge clock); while (req_stall);
      position_board.note_atom(mask, mass, fx, fy, fz, nx, ny, nz, px, py, pz, last);
   endtask

   function automatic logic [31:0] pick32();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_mass();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 3);
         1: return 32'hffffffff;
         2: return $urandom;
         default: return $urandom_range(1 << 14, 1 << 22);
      endcase
   endfunction

   task automatic random_atoms(int count);
      int g;
      for (int i = 0; i < count; i++) begin
         g = gap_length();
         if (g > 0) begin
            req_valid <= 0;
            repeat (g) @(posedge clock);
         end
         send_atom($urandom_range(0, 3) == 0 ? $urandom : position_board.group_bit |
                   ($urandom & {31'b0, $urandom_range(0, 1)}),
                   pick_mass(), pick32(), pick32(), pick32(),
                   $urandom, $urandom, $urandom, pick32(), pick32(), pick32(),
                   $urandom_range(0, 15) == 0);
      end
      req_valid <= 0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Registers are still at reset: only pass-through or zero moves.
      send_atom(32'h1, 32'h10000, 32'h7fffffff, 32'h80000000, 0,
                16'h7fff, 16'h8000, 0, 32'h12345678, 32'h80000000, 32'h7fffffff, 1);
      send_atom(32'hfffffffe, 0, 1, 2, 3, 1, 2, 3, 32'hffffffff, 0, 1, 0);
      req_valid <= 0;
      wait_idle();
      write_reg(REG_FORCE_TIME_FACTOR, 32'h0001_0000);
      write_reg(REG_STEP_TIME, 32'h0000_8000);
      write_reg(REG_NOISE_GAIN, 32'h0001_0000);
      write_reg(REG_GROUP_BIT, 32'h8000_0001);
      write_reg(3'd7, 32'hdeadbeef);
      send_atom(32'h1, 0, 32'h10000, -32'sh10000, 0, 16'h1000, -16'sh1000, 0,
                0, 0, 0, 0);
      send_atom(32'h80000000, 32'hffffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                16'h7fff, 16'h8000, 16'h0001, 32'h7fff0000, 32'h80010000, 0, 1);
      send_atom(32'h2, 32'h10000, 5, 5, 5, 1, 1, 1, 7, 8, 9, 0);
      send_atom(32'hffffffff, 1, 32'h7fffffff, 32'h80000000, 32'h100,
                16'h7fff, 16'h8000, 0, 32'h7fffffff, 32'h80000000, 0, 1);
      req_valid <= 0;
      wait_idle();
      write_reg(REG_FORCE_TIME_FACTOR, 32'hffffffff);
      write_reg(REG_STEP_TIME, 32'hffffffff);
      write_reg(REG_NOISE_GAIN, 32'hffffffff);
      write_reg(REG_GROUP_BIT, 32'hffffffff);
      send_atom(32'h1, 1, 1, -1, 0, 16'h7fff, 16'h8000, 0, 0, 0, 0, 0);
      send_atom(32'h4, 32'hffffffff, 0, 0, 0, 16'h0001, 16'hffff, 0,
                32'h7fffffff, 32'h80000000, 0, 1);
      random_atoms(400);
      wait_idle();
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(REG_FORCE_TIME_FACTOR, $urandom_range(0, 1 << 18));
         write_reg(REG_STEP_TIME, ph == 3 ? 32'h0 : $urandom_range(0, 1 << 17));
         write_reg(REG_NOISE_GAIN, $urandom_range(0, 1 << 18));
         write_reg(REG_GROUP_BIT, ph == 2 ? 32'h0 : 32'h1 << $urandom_range(0, 31));
         random_atoms(400);
         wait_idle();
      end
      draining = 1;
      repeat (20) @(posedge clock);
      $display("Checked %0d atom transactions over seven register settings:",
               position_board.checked);
      $display("%0d moved, %0d clipped.", position_board.moved_count,
               position_board.sat_count);
      if (position_board.errors == 0 && position_board.pending_results.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #20ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule

@@ brownian_euler_position_update_core.f @@
rtl/bepu_pkg.sv
rtl/bepu_sqrt.sv
rtl/bepu_div.sv
rtl/bepu_lane.sv
rtl/brownian_euler_position_update_core.sv
rtl/bepu_checker.sv
dv/tb_brownian_euler_position_update_core.sv
